FILE: rtl/csq_pkg.sv
`timescale 1ns / 1ps
package csq_pkg;
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic [2:0] CMD_START  = 3'd0;
    localparam logic [2:0] CMD_END    = 3'd1;
    localparam logic [2:0] CMD_ADV    = 3'd2;
    localparam logic [2:0] CMD_INSERT = 3'd3;
    localparam logic [2:0] CMD_ATTACH = 3'd4;
    localparam logic [2:0] CMD_REMOVE = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_CUR  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [DATA_WIDTH-1:0] data_t;
endpackage

FILE: rtl/csq_ram.sv
`timescale 1ns / 1ps
module csq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/cursor_sequence_store_unit.sv
`timescale 1ns / 1ps
// ordered sequence store with a cursor, entries held in one synchronous ram
// command channel: a beat is taken when start is high and busy is low; command
// and entry_value are sampled at that edge
// result channel: done is high for exactly one cycle with status, item_count,
// has_current, current_value and cursor_position; the receiver cannot stall,
// so the beat is taken at the edge that ends that cycle
// start, end, advance, failed commands and removing the last entry go from
// accept through S_READ to S_RESP; insert or attach passes S_UP and S_FLUSH
// when entries move, then S_PUT; remove that moves entries passes S_DN and
// S_FLUSH; both then go on through S_READ and S_RESP
// insert and remove move one entry per cycle through the single write port of
// the ram, and the current entry is read back through its registered read port
// before the result is shown
// one command is in flight at a time; busy is high from accept through done
// reset clears count and cursor (empty store, no current entry); ram contents
// are not cleared, only entries below the count are ever shown on current_value
module cursor_sequence_store_unit
    import csq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [31:0] entry_value,
    output logic        done,
    output logic [1:0]  status,
    output logic [6:0]  item_count,
    output logic        has_current,
    output logic [31:0] current_value,
    output logic [6:0]  cursor_position
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UP    = 3'd1;
    localparam logic [2:0] S_DN    = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0] state_reg, state_next;
    cnt_t       count_reg, count_next;
    cnt_t       cursor_reg, cursor_next;
    cnt_t       ptr_reg, ptr_next;
    cnt_t       pos_reg, pos_next;
    cnt_t       wa_reg, wa_next;
    logic       wpend_reg, wpend_next;
    logic       up_reg, up_next;
    logic [1:0] status_reg, status_next;
    data_t      val_reg, val_next;

    logic       ram_we;
    addr_t      ram_waddr, ram_raddr;
    data_t      ram_wdata, ram_rdata;
    logic       has_cur;
    cnt_t       ins_pos;

    assign has_cur = cursor_reg < count_reg;

    always_comb
    begin
        if (command == CMD_INSERT)
            ins_pos = has_cur ? cursor_reg : '0;
        else
            ins_pos = has_cur ? cnt_t'(cursor_reg + 1'b1) : count_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        wa_next     = wa_reg;
        wpend_next  = wpend_reg;
        up_next     = up_reg;
        status_next = status_reg;
        val_next    = val_reg;
        ram_we      = 1'b0;
        ram_waddr   = wa_reg[ADDR_W-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = ptr_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = ST_OK;
                    wpend_next  = 1'b0;
                    state_next  = S_READ;
                    val_next    = data_t'(entry_value);
                    case (command)
                        CMD_START: cursor_next = '0;
                        CMD_END:
                        begin
                            if (count_reg != '0)
                                cursor_next = cnt_t'(count_reg - 1'b1);
                        end
                        CMD_ADV:
                        begin
                            if (!has_cur)
                                status_next = ST_NO_CUR;
                            else
                                cursor_next = cnt_t'(cursor_reg + 1'b1);
                        end
                        CMD_INSERT, CMD_ATTACH:
                        begin
                            if (count_reg >= cnt_t'(CAPACITY))
                                status_next = ST_FULL;
                            else
                            begin
                                pos_next    = ins_pos;
                                cursor_next = ins_pos;
                                count_next  = cnt_t'(count_reg + 1'b1);
                                ptr_next    = cnt_t'(count_reg - 1'b1);
                                up_next     = 1'b1;
                                state_next  = (count_reg > ins_pos) ? S_UP : S_PUT;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!has_cur)
                                status_next = ST_NO_CUR;
                            else
                            begin
                                count_next = cnt_t'(count_reg - 1'b1);
                                up_next    = 1'b0;
                                if (cnt_t'(cursor_reg + 1'b1) < count_reg)
                                begin
                                    ptr_next   = cnt_t'(cursor_reg + 1'b1);
                                    state_next = S_DN;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // open a gap: read k-1, write it to k on the next cycle
            S_UP:
            begin
                ram_we     = wpend_reg;
                wpend_next = 1'b1;
                wa_next    = cnt_t'(ptr_reg + 1'b1);
                if (ptr_reg == pos_reg)
                    state_next = S_FLUSH;
                else
                    ptr_next = cnt_t'(ptr_reg - 1'b1);
            end
            // close a gap: read k+1, write it to k; count is already the new one
            S_DN:
            begin
                ram_we     = wpend_reg;
                wpend_next = 1'b1;
                wa_next    = cnt_t'(ptr_reg - 1'b1);
                if (ptr_reg == count_reg)
                    state_next = S_FLUSH;
                else
                    ptr_next = cnt_t'(ptr_reg + 1'b1);
            end
            S_FLUSH:
            begin
                ram_we     = 1'b1;
                wpend_next = 1'b0;
                state_next = up_reg ? S_PUT : S_READ;
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[ADDR_W-1:0];
                ram_wdata  = val_reg;
                state_next = S_READ;
            end
            S_READ:
            begin
                ram_raddr  = cursor_reg[ADDR_W-1:0];
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
            wpend_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            wpend_reg  <= wpend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        wa_reg     <= wa_next;
        up_reg     <= up_next;
        status_reg <= status_next;
        val_reg    <= val_next;
    end

    csq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy            = state_reg != S_IDLE;
    assign done            = state_reg == S_RESP;
    assign status          = status_reg;
    assign item_count      = 7'(count_reg);
    assign has_current     = has_cur;
    assign current_value   = has_cur ? 32'(ram_rdata) : '0;
    assign cursor_position = 7'(cursor_reg);

    assert property (@(posedge clk) disable iff (!rst_n) cursor_reg <= count_reg)
        else $error("cursor beyond count");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= cnt_t'(CAPACITY))
        else $error("count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n) !busy |-> !ram_we)
        else $error("ram write while idle");
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");
endmodule
